>>> rtl/bsp_pkg.sv
// Shared types and codes of the buffered serial port flow control core.
package bsp_pkg;

   localparam logic [2:0] MODE_PUT     = 3'd0;
   localparam logic [2:0] MODE_GET     = 3'd1;
   localparam logic [2:0] MODE_LINE_RX = 3'd2;
   localparam logic [2:0] MODE_TX_UDRE = 3'd3;
   localparam logic [2:0] MODE_TX_DONE = 3'd4;
   localparam logic [2:0] MODE_TX_EN   = 3'd5;
   localparam logic [2:0] MODE_FLUSH   = 3'd6;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RX_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_TX_FULL = 2'd2;
   localparam logic [1:0] STATUS_DROPPED = 2'd3;

   localparam logic [1:0] DIR_UNSET = 2'd0;
   localparam logic [1:0] DIR_OFF   = 2'd1;
   localparam logic [1:0] DIR_ON    = 2'd2;

   localparam int unsigned CSR_HALF_DUPLEX = 0;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       line_error;
      logic       clear_to_send;
      logic       enable_value;
   } bsp_item_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [1:0] status;
      logic       line_send_valid;
      logic [7:0] line_send_byte;
      logic       request_to_send;
      logic       transmitter_on;
      logic       receiver_on;
      logic [6:0] rx_fill;
      logic [6:0] tx_fill;
   } bsp_rsp_type;

endpackage

>>> rtl/buffered_serial_port_flow_control_core.sv
// Top level of the buffered serial port flow control core.
//
// One event beat enters on the req_ channel (valid/stall) and produces exactly
// one result beat on the rsp_ channel. The event is chosen by req_mode: host
// put, get, transmitter enable or flush, a received line byte, a transmit
// register empty tick or a transmit complete tick.
// Both FIFOs live in registered-read memories addressed by their head and
// tail pointers. An accepted beat reads the FIFO heads at acceptance and is
// held in the item register; it is processed once the read data are
// registered and the result register is free, and its result is then
// registered. A new beat is not accepted until the last one is processed.
// While the result register holds an untaken beat, the next beat may still
// be accepted; it waits in the process stage until rsp_stall falls.
// Reset (synchronous, active high) empties both FIFOs, clears the flow
// control flags and leaves the directions unset; the FIFO memories are not
// cleared, as no entry is read before it is written.
// half_duplex is written through the APB-style port at byte address 0; the
// user changes it only while the block is idle, the block does not enforce it.
module buffered_serial_port_flow_control_core
   import bsp_pkg::*;
#(
   parameter int unsigned RX_DEPTH = 64,
   parameter int unsigned TX_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_line_error,
   input  logic        req_clear_to_send,
   input  logic        req_enable_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_line_send_valid,
   output logic [7:0]  rsp_line_send_byte,
   output logic        rsp_request_to_send,
   output logic        rsp_transmitter_on,
   output logic        rsp_receiver_on,
   output logic [6:0]  rsp_rx_fill,
   output logic [6:0]  rsp_tx_fill
);

   localparam int unsigned RAW = $clog2(RX_DEPTH);
   localparam int unsigned TAW = $clog2(TX_DEPTH);

   logic           half_duplex_ff, half_duplex_in;
   logic           csr_write;
   logic           csr_sel_hd;
   bsp_item_type   item;
   bsp_rsp_type    rsp_beat;
   logic           rx_we, tx_we;
   logic [RAW-1:0] rx_waddr, rx_raddr;
   logic [TAW-1:0] tx_waddr, tx_raddr;
   logic [7:0]     rx_wdata, rx_rdata, tx_wdata, tx_rdata;

   assign pready     = 1'b1;
   assign csr_sel_hd = (32'(paddr[2]) == CSR_HALF_DUPLEX) && (paddr[1:0] == 2'b00);
   assign csr_write  = psel && penable && pwrite && pready;
   assign half_duplex_in = (csr_write && csr_sel_hd) ? pwdata[0] : half_duplex_ff;
   assign prdata     = csr_sel_hd ? {31'b0, half_duplex_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_duplex_ff <= 1'b0;
      end else begin
         half_duplex_ff <= half_duplex_in;
      end
   end

   assign item.mode          = req_mode;
   assign item.data_byte     = req_data_byte;
   assign item.line_error    = req_line_error;
   assign item.clear_to_send = req_clear_to_send;
   assign item.enable_value  = req_enable_value;

   bsp_ram #(.DEPTH(RX_DEPTH), .AW(RAW)) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (rx_wdata),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   bsp_ram #(.DEPTH(TX_DEPTH), .AW(TAW)) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_waddr),
      .wdata (tx_wdata),
      .raddr (tx_raddr),
      .rdata (tx_rdata)
   );

   bsp_engine #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH),
      .RAW      (RAW),
      .TAW      (TAW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .half_duplex (half_duplex_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .rx_we       (rx_we),
      .rx_waddr    (rx_waddr),
      .rx_wdata    (rx_wdata),
      .rx_raddr    (rx_raddr),
      .rx_rdata    (rx_rdata),
      .tx_we       (tx_we),
      .tx_waddr    (tx_waddr),
      .tx_wdata    (tx_wdata),
      .tx_raddr    (tx_raddr),
      .tx_rdata    (tx_rdata)
   );

   assign rsp_read_byte       = rsp_beat.read_byte;
   assign rsp_status          = rsp_beat.status;
   assign rsp_line_send_valid = rsp_beat.line_send_valid;
   assign rsp_line_send_byte  = rsp_beat.line_send_byte;
   assign rsp_request_to_send = rsp_beat.request_to_send;
   assign rsp_transmitter_on  = rsp_beat.transmitter_on;
   assign rsp_receiver_on     = rsp_beat.receiver_on;
   assign rsp_rx_fill         = rsp_beat.rx_fill;
   assign rsp_tx_fill         = rsp_beat.tx_fill;

endmodule

>>> rtl/bsp_ram.sv
// Single-port-write, registered-read byte memory for one FIFO.
module bsp_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bsp_engine.sv
// Event sequencer: FIFO pointers, flow control flags and the result register.
module bsp_engine
   import bsp_pkg::*;
#(
   parameter int unsigned RX_DEPTH = 64,
   parameter int unsigned TX_DEPTH = 64,
   parameter int unsigned RAW      = 6,
   parameter int unsigned TAW      = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           half_duplex,
   input  logic           req_valid,
   output logic           req_stall,
   input  bsp_item_type   req_item,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output bsp_rsp_type    rsp_beat,
   output logic           rx_we,
   output logic [RAW-1:0] rx_waddr,
   output logic [7:0]     rx_wdata,
   output logic [RAW-1:0] rx_raddr,
   input  logic [7:0]     rx_rdata,
   output logic           tx_we,
   output logic [TAW-1:0] tx_waddr,
   output logic [7:0]     tx_wdata,
   output logic [TAW-1:0] tx_raddr,
   input  logic [7:0]     tx_rdata
);

   localparam int unsigned RCW = $clog2(RX_DEPTH + 1);
   localparam int unsigned TCW = $clog2(TX_DEPTH + 1);
   localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
   localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);
   localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
   localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);

   logic           busy_ff, busy_in;
   bsp_item_type   item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   bsp_rsp_type    rsp_ff, rsp_in;
   logic [RAW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RCW-1:0] rx_count_ff, rx_count_in;
   logic [TAW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TCW-1:0] tx_count_ff, tx_count_in;
   logic           rx_stopped_ff, rx_stopped_in;
   logic [1:0]     tx_state_ff, tx_state_in, rx_state_ff, rx_state_in;
   logic           en_udre_ff, en_udre_in, en_txc_ff, en_txc_in;

   logic           accept, process;
   logic           set_req, set_on;
   logic           rx_open, rx_push, tx_push;
   logic [1:0]     want;

   assign accept    = req_valid && !busy_ff;
   assign process   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   assign rx_raddr = rx_head_ff;
   assign tx_raddr = tx_head_ff;
   assign rx_waddr = rx_tail_ff;
   assign tx_waddr = tx_tail_ff;
   assign rx_wdata = item_ff.data_byte;
   assign tx_wdata = item_ff.data_byte;
   assign rx_we    = process && rx_push;
   assign tx_we    = process && tx_push;

   assign rx_open = (rx_state_ff != DIR_OFF) && !rx_stopped_ff && (rx_count_ff < RX_FULL);

   always_comb begin
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      rx_count_in   = rx_count_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      tx_count_in   = tx_count_ff;
      rx_stopped_in = rx_stopped_ff;
      tx_state_in   = tx_state_ff;
      rx_state_in   = rx_state_ff;
      en_udre_in    = en_udre_ff;
      en_txc_in     = en_txc_ff;
      set_req       = 1'b0;
      set_on        = 1'b0;
      rx_push       = 1'b0;
      tx_push       = 1'b0;
      want          = DIR_OFF;
      rsp_in        = '0;
      unique case (item_ff.mode)
         MODE_PUT: begin
            if (tx_count_ff >= TX_FULL) begin
               rsp_in.status = STATUS_TX_FULL;
            end else begin
               tx_push     = 1'b1;
               tx_tail_in  = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
               tx_count_in = tx_count_ff + 1'b1;
               set_req     = 1'b1;
               set_on      = 1'b1;
            end
         end
         MODE_GET: begin
            if (rx_count_ff == '0) begin
               rx_stopped_in = 1'b0;
               rsp_in.status = STATUS_RX_EMPTY;
            end else begin
               rsp_in.read_byte = rx_rdata;
               rx_head_in  = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
               rx_count_in = rx_count_ff - 1'b1;
            end
         end
         MODE_LINE_RX: begin
            if (item_ff.line_error || !rx_open) begin
               rsp_in.status = STATUS_DROPPED;
            end else begin
               rx_push     = 1'b1;
               rx_tail_in  = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;
               rx_count_in = rx_count_ff + 1'b1;
               if (rx_count_in >= RX_FULL) begin
                  rx_stopped_in = 1'b1;
               end
            end
         end
         MODE_TX_UDRE: begin
            if (en_udre_ff) begin
               if (tx_count_ff == '0) begin
                  en_udre_in = 1'b0;
                  en_txc_in  = 1'b1;
               end else if (item_ff.clear_to_send) begin
                  rsp_in.line_send_valid = 1'b1;
                  rsp_in.line_send_byte  = tx_rdata;
                  tx_head_in  = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
                  tx_count_in = tx_count_ff - 1'b1;
               end
            end
         end
         MODE_TX_DONE: begin
            if (en_txc_ff) begin
               if (tx_count_ff == '0) begin
                  set_req = 1'b1;
               end else begin
                  en_txc_in  = 1'b0;
                  en_udre_in = 1'b1;
               end
            end
         end
         MODE_TX_EN: begin
            set_req = 1'b1;
            set_on  = item_ff.enable_value;
         end
         MODE_FLUSH: begin
            rx_head_in  = '0;
            rx_tail_in  = '0;
            rx_count_in = '0;
            tx_head_in  = '0;
            tx_tail_in  = '0;
            tx_count_in = '0;
         end
         default: begin
         end
      endcase
      want = set_on ? DIR_ON : DIR_OFF;
      if (set_req && (tx_state_ff != want)) begin
         en_udre_in  = set_on;
         en_txc_in   = 1'b0;
         tx_state_in = want;
         if (half_duplex) begin
            rx_state_in = set_on ? DIR_OFF : DIR_ON;
         end
      end
      rsp_in.request_to_send = !rx_stopped_in;
      rsp_in.transmitter_on  = (tx_state_in == DIR_ON);
      rsp_in.receiver_on     = (rx_state_in != DIR_OFF) && !rx_stopped_in;
      rsp_in.rx_fill         = 7'(rx_count_in);
      rsp_in.tx_fill         = 7'(tx_count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (process) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         rx_count_ff   <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         tx_count_ff   <= '0;
         rx_stopped_ff <= 1'b0;
         tx_state_ff   <= DIR_UNSET;
         rx_state_ff   <= DIR_UNSET;
         en_udre_ff    <= 1'b0;
         en_txc_ff     <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            rx_head_ff    <= rx_head_in;
            rx_tail_ff    <= rx_tail_in;
            rx_count_ff   <= rx_count_in;
            tx_head_ff    <= tx_head_in;
            tx_tail_ff    <= tx_tail_in;
            tx_count_ff   <= tx_count_in;
            rx_stopped_ff <= rx_stopped_in;
            tx_state_ff   <= tx_state_in;
            rx_state_ff   <= rx_state_in;
            en_udre_ff    <= en_udre_in;
            en_txc_ff     <= en_txc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   a_rx_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RX_FULL) else $error("rx count beyond depth");

   a_tx_count_bound: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff <= TX_FULL) else $error("tx count beyond depth");

   a_full_stops_rx: assert property (@(posedge clock) disable iff (reset)
      (rx_count_ff == RX_FULL) |-> rx_stopped_ff) else $error("full rx fifo not stopped");

   a_process_result: assert property (@(posedge clock) disable iff (reset)
      process |=> (rsp_valid_ff && !busy_ff)) else $error("processed beat lost");

endmodule
